@@ design/eic_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event interrupt controller package
// Shared types, codes and sizes for the event interrupt controller.
// ----------------------------------------------------------------------------
package eic_pkg;

  // Status words, and mask words per output line (range 1 to 4).
  localparam int unsigned NUM_GROUPS = 3;
  // Output interrupt lines, one mask group each.
  localparam int unsigned NUM_LINES  = 3;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned LINE_W  = 4;
  localparam int unsigned EVNUM_W = 7;
  localparam int unsigned LVL_W   = 2;
  localparam int unsigned BIT_W   = 5;

  // Processor line numbers served by the demux, levels 0, 1 and 2.
  localparam logic [LINE_W-1:0] LINE_LVL0 = 4'd13;
  localparam logic [LINE_W-1:0] LINE_LVL1 = 4'd11;
  localparam logic [LINE_W-1:0] LINE_LVL2 = 4'd9;

  localparam logic [LVL_W-1:0] LVL0 = 2'd0;
  localparam logic [LVL_W-1:0] LVL1 = 2'd1;
  localparam logic [LVL_W-1:0] LVL2 = 2'd2;

  typedef enum logic [1:0] {
    CMD_EVENT = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_DEMUX = 2'd3
  } cmd_e;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NUM_LINES-1:0][WORD_W-1:0] pend_t;

  // One item on its way through the processing pass.
  typedef struct packed {
    logic              valid;
    cmd_e              cmd;
    logic [IDX_W-1:0]  idx;
    word_t             data;
    logic [LINE_W-1:0] line;
  } step_t;

  // Demux findings handed to the result register.
  typedef struct packed {
    logic [EVNUM_W-1:0] event_number;
    logic               event_found;
    logic [LINE_W-1:0]  passed_line;
  } demux_t;

endpackage : eic_pkg
`default_nettype wire

@@ design/eic_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event interrupt controller register file
// Status and mask words, write-one-to-clear update, bus read and line requests.
// ----------------------------------------------------------------------------
module eic_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire eic_pkg::step_t                 step_i,
  output eic_pkg::word_t                      rd_data_o,
  output eic_pkg::pend_t                      pend_o,
  output logic [eic_pkg::NUM_LINES-1:0]       line_req_o
);
  import eic_pkg::*;

  word_t status_q [NUM_GROUPS];
  word_t status_d [NUM_GROUPS];
  word_t mask_q   [NUM_LINES][NUM_GROUPS];
  word_t mask_d   [NUM_LINES][NUM_GROUPS];

  always_comb begin
    rd_data_o = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      status_d[g] = status_q[g];
      if (step_i.valid && step_i.idx == IDX_W'(g)) begin
        case (step_i.cmd)
          CMD_EVENT: status_d[g] = status_q[g] | step_i.data;
          CMD_WRITE: status_d[g] = status_q[g] & ~step_i.data;
          CMD_READ:  rd_data_o   = status_q[g];
          default:   status_d[g] = status_q[g];
        endcase
      end
    end
    for (int l = 0; l < NUM_LINES; l++) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        mask_d[l][g] = mask_q[l][g];
        if (step_i.valid && step_i.idx == IDX_W'(4 + 4 * l + g)) begin
          case (step_i.cmd)
            CMD_WRITE: mask_d[l][g] = step_i.data;
            CMD_READ:  rd_data_o    = mask_q[l][g];
            default:   mask_d[l][g] = mask_q[l][g];
          endcase
        end
      end
    end
  end

  // Line requests reflect the state after this item's update.
  always_comb begin
    for (int l = 0; l < NUM_LINES; l++) begin
      line_req_o[l] = 1'b0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        line_req_o[l] = line_req_o[l] | (|(status_d[g] & mask_d[l][g]));
      end
    end
  end

  // Pending word per demux level: status of that level under its own mask.
  for (genvar l = 0; l < NUM_LINES; l++) begin : g_pend
    if (l < NUM_GROUPS) begin : g_used
      assign pend_o[l] = status_q[l] & mask_q[l][l];
    end else begin : g_none
      assign pend_o[l] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        status_q[g] <= '0;
      end
      for (int l = 0; l < NUM_LINES; l++) begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
          mask_q[l][g] <= '0;
        end
      end
    end else begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        status_q[g] <= status_d[g];
      end
      for (int l = 0; l < NUM_LINES; l++) begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
          mask_q[l][g] <= mask_d[l][g];
        end
      end
    end
  end

endmodule : eic_regs
`default_nettype wire

@@ design/eic_demux.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event interrupt controller demux
// Maps a processor line to its level and finds the lowest pending event.
// ----------------------------------------------------------------------------
module eic_demux (
  input  wire eic_pkg::step_t  step_i,
  input  wire eic_pkg::pend_t  pend_i,
  output eic_pkg::demux_t      demux_o
);
  import eic_pkg::*;

  logic              known;
  logic [LVL_W-1:0]  level;
  word_t             sel;
  logic              hit;
  logic [BIT_W-1:0]  bit_pos;

  always_comb begin
    known = 1'b1;
    level = LVL0;
    unique case (step_i.line)
      LINE_LVL0: level = LVL0;
      LINE_LVL1: level = LVL1;
      LINE_LVL2: level = LVL2;
      default:   known = 1'b0;
    endcase
  end

  assign sel = known ? pend_i[level] : '0;

  // Lowest set bit wins: scan from the top so the last hit is the lowest.
  always_comb begin
    hit     = 1'b0;
    bit_pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (sel[j]) begin
        hit     = 1'b1;
        bit_pos = BIT_W'(j);
      end
    end
  end

  always_comb begin
    demux_o = '0;
    if (step_i.cmd == CMD_DEMUX) begin
      demux_o.event_found = hit;
      if (hit) begin
        demux_o.event_number = {level, bit_pos};
      end else begin
        demux_o.passed_line = step_i.line;
      end
    end
  end

endmodule : eic_demux
`default_nettype wire

@@ design/event_interrupt_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event interrupt controller
// Status/mask interrupt controller with write-one-to-clear status and demux.
// ----------------------------------------------------------------------------
// Every item goes through one pass: it is caught in an input register, then
// once the result register is free or draining it updates the status and
// mask words, is decoded against them and its result is stored in the output
// register. One item per cycle is sustained while the output is not stalled;
// the output register lets a new item be accepted while a result waits, and
// the input register holds an item while the output is stalled. Status words
// take event bits by OR on arrival and are cleared by writing ones; mask
// words are written whole. A read of an unused word returns zero. A demux
// query on line 13, 11 or 9 returns the lowest pending unmasked event of
// level 0, 1 or 2 (bit plus 32 times level), otherwise it passes the line
// number through. line_requests always shows the three output lines after
// the item's update. Reset clears all status and mask words (all masked).
// ----------------------------------------------------------------------------
module event_interrupt_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata, low bit up: cmd[1:0], word_index[5:2], bus_data[37:6],
  // line_number[41:38], zero fill [47:42]
  input  wire logic [47:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata, low bit up: read_data[31:0], event_number[38:32],
  // event_found[39], passed_line[43:40], line_requests[46:44], zero fill [47]
  output logic [47:0]      m_axis_tdata_o
);
  import eic_pkg::*;

  logic           in_valid_q;
  step_t          in_item_q;
  logic           out_valid_q;
  logic [47:0]    out_data_q;
  logic           fire;
  step_t          step;
  word_t          rd_data;
  pend_t          pend;
  logic [NUM_LINES-1:0] line_req;
  demux_t         demux;

  // Process the held item when the result register is free or draining.
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;

  assign step = '{valid: fire, cmd: in_item_q.cmd, idx: in_item_q.idx,
                  data: in_item_q.data, line: in_item_q.line};

  eic_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .rd_data_o  (rd_data),
    .pend_o     (pend),
    .line_req_o (line_req)
  );

  eic_demux u_demux (
    .step_i  (step),
    .pend_i  (pend),
    .demux_o (demux)
  );

  // Input register: hold the item until the pass can take it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.valid <= 1'b1;
      in_item_q.cmd   <= cmd_e'(s_axis_tdata_i[1:0]);
      in_item_q.idx   <= s_axis_tdata_i[5:2];
      in_item_q.data  <= s_axis_tdata_i[37:6];
      in_item_q.line  <= s_axis_tdata_i[41:38];
    end
  end

  // Result register: advance on fire, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= {1'b0, line_req, demux.passed_line, demux.event_found,
                     demux.event_number, rd_data};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule : event_interrupt_controller
`default_nettype wire

@@ design/eic_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Event interrupt controller checker
// Port-level assertions on result items, bound to the top level.
// ----------------------------------------------------------------------------
module eic_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [47:0] m_axis_tdata_o
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // A found event never passes the line through and never carries read data.
  a_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[39] |->
      m_axis_tdata_o[43:40] == 4'd0 && m_axis_tdata_o[31:0] == 32'd0)
    else $error("found event with passed line or read data");

  // Without a found event the event number stays zero.
  a_nofind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[39] |-> m_axis_tdata_o[38:32] == 7'd0)
    else $error("event number without found flag");

  // The input side stalls only behind a waiting result that is not taken.
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a blocked result");

  // No result is offered while reset is held.
  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

endmodule : eic_checker

bind event_interrupt_controller eic_checker u_eic_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire

@@ dv/event_interrupt_controller_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event interrupt controller testbench
// Drives register accesses, event arrivals and demux queries into the stream
// input, predicts every result from a local copy of the status and mask words,
// and checks each result field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module event_interrupt_controller_test;
  import eic_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 12;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned RANDOM_ITEMS    = 1700;
  localparam int unsigned BURST_ITEMS     = 40;
  localparam int unsigned MAX_IDLE        = 11;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned MODE_STRETCH    = 150;

  // Word offsets of the register map.
  localparam logic [IDX_W-1:0] IDX_STATUS0   = 4'd0;
  localparam logic [IDX_W-1:0] IDX_STATUS1   = 4'd1;
  localparam logic [IDX_W-1:0] IDX_STATUS2   = 4'd2;
  localparam logic [IDX_W-1:0] IDX_HOLE      = 4'd3;   // gap after the status words
  localparam logic [IDX_W-1:0] IDX_MASK_BASE = 4'd4;
  localparam logic [IDX_W-1:0] IDX_TOP       = 4'd15;  // group 3 of line 2, unused

  // Processor lines that the demux does not serve.
  localparam logic [LINE_W-1:0] LINE_OTHER_LO = 4'd0;
  localparam logic [LINE_W-1:0] LINE_OTHER_HI = 4'd15;

  localparam word_t ALL_ONES = 32'hFFFF_FFFF;
  localparam word_t NO_BITS  = 32'h0000_0000;
  localparam word_t TOP_BIT  = 32'h8000_0000;
  localparam word_t LOW_BIT  = 32'h0000_0001;

  typedef struct packed {
    cmd_e              cmd;
    logic [IDX_W-1:0]  idx;
    word_t             data;
    logic [LINE_W-1:0] line;
  } ctrl_item_t;

  typedef struct packed {
    word_t                read_data;
    logic [EVNUM_W-1:0]   event_number;
    logic                 event_found;
    logic [LINE_W-1:0]    passed_line;
    logic [NUM_LINES-1:0] line_requests;
  } ctrl_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // fields, low bit up: cmd, word_index, bus_data, line_number, zero fill
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // fields, low bit up: read_data, event_number, event_found, passed_line,
  // line_requests, zero fill
  logic [47:0] m_axis_tdata;

  // Local copy of the controller state.
  word_t status_words [NUM_GROUPS];
  word_t mask_words   [NUM_LINES][NUM_GROUPS];

  ctrl_result_t expected_results[$];
  int unsigned  mismatch_cnt;
  int unsigned  cycle_cnt;
  bit           send_idle_en;
  bit           recv_idle_en;
  int unsigned  hold_off_req;

  event_interrupt_controller DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [IDX_W-1:0] mask_index(input int unsigned ln,
                                                  input int unsigned grp);
    return IDX_W'(IDX_MASK_BASE + 4 * ln + grp);
  endfunction

  // Map a word offset onto a mask word; fail for holes and absent groups.
  function automatic bit mask_slot_of(input logic [IDX_W-1:0] idx,
                                      output int unsigned ln,
                                      output int unsigned grp);
    ln  = 0;
    grp = 0;
    if (idx < IDX_MASK_BASE) return 1'b0;
    ln  = int'(idx >> 2) - 1;
    grp = int'(idx[1:0]);
    return (ln < NUM_LINES) && (grp < NUM_GROUPS);
  endfunction

  // Apply one item to the local state and return the result it causes.
  function automatic ctrl_result_t predict_controller(input ctrl_item_t it);
    ctrl_result_t res;
    int unsigned  ln;
    int unsigned  grp;
    int unsigned  lvl;
    bit           known;
    word_t        pend;
    res = '0;
    case (it.cmd)
      CMD_EVENT: begin
        // Arrivals on anything but a status word are dropped.
        if (it.idx < NUM_GROUPS) status_words[it.idx] |= it.data;
      end
      CMD_WRITE: begin
        if (it.idx < NUM_GROUPS) status_words[it.idx] &= ~it.data;
        else if (mask_slot_of(it.idx, ln, grp)) mask_words[ln][grp] = it.data;
      end
      CMD_READ: begin
        if (it.idx < NUM_GROUPS) res.read_data = status_words[it.idx];
        else if (mask_slot_of(it.idx, ln, grp)) res.read_data = mask_words[ln][grp];
      end
      default: begin
        known = 1'b1;
        lvl   = 0;
        if (it.line == LINE_LVL0) lvl = LVL0;
        else if (it.line == LINE_LVL1) lvl = LVL1;
        else if (it.line == LINE_LVL2) lvl = LVL2;
        else known = 1'b0;
        if (known && lvl < NUM_GROUPS) begin
          pend = status_words[lvl] & mask_words[lvl][lvl];
          // Scan downward so the lowest pending bit wins.
          for (int j = WORD_W - 1; j >= 0; j--) begin
            if (pend[j]) res.event_number = EVNUM_W'(j + 32 * lvl);
          end
          res.event_found = |pend;
        end
        if (!res.event_found) res.passed_line = it.line;
      end
    endcase
    // Line requests reflect the state after this item's update.
    for (int l = 0; l < NUM_LINES; l++) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        if ((status_words[g] & mask_words[l][g]) != '0) res.line_requests[l] = 1'b1;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic ctrl_item_t make_item(input cmd_e cmd, input logic [IDX_W-1:0] idx,
                                           input word_t data, input logic [LINE_W-1:0] line);
    ctrl_item_t it;
    it.cmd  = cmd;
    it.idx  = idx;
    it.data = data;
    it.line = line;
    return it;
  endfunction

  // Mostly well-formed traffic: valid offsets, sparse event bits, served lines.
  function automatic ctrl_item_t random_item();
    ctrl_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 6) it.cmd = CMD_EVENT;
    else if (pick < 11) it.cmd = CMD_WRITE;
    else if (pick < 14) it.cmd = CMD_READ;
    else it.cmd = CMD_DEMUX;

    pick = $urandom_range(0, 9);
    if (pick < 4) it.idx = IDX_W'($urandom_range(0, NUM_GROUPS - 1));
    else if (pick < 7)
      it.idx = mask_index($urandom_range(0, NUM_LINES - 1), $urandom_range(0, NUM_GROUPS - 1));
    else it.idx = IDX_W'($urandom_range(0, 15));

    pick = $urandom_range(0, 9);
    if (pick < 4) it.data = LOW_BIT << $urandom_range(0, WORD_W - 1);
    else if (pick < 6) it.data = $urandom() & $urandom() & $urandom();
    else if (pick < 8) it.data = $urandom();
    else if (pick < 9) it.data = ALL_ONES;
    else it.data = NO_BITS;

    pick = $urandom_range(0, 3);
    if (it.cmd == CMD_DEMUX && pick != 0) begin
      pick = $urandom_range(0, 2);
      it.line = (pick == 0) ? LINE_LVL0 : (pick == 1) ? LINE_LVL1 : LINE_LVL2;
    end else begin
      it.line = LINE_W'($urandom_range(0, 15));
    end
    return it;
  endfunction

  // Offer one item, hold it until the handshake, then record its expectation.
  // Valid stays high between back-to-back items; it only drops for a gap.
  task automatic send_item(input ctrl_item_t it);
    int unsigned gap;
    bit          took;
    gap = send_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, it.line, it.data, it.idx, it.cmd};
    // Sample ready mid-cycle, where it is stable up to the next edge.
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    expected_results.push_back(predict_controller(it));
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic check_result(input logic [47:0] beat);
    ctrl_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing outstanding", beat[31:0], NO_BITS);
      return;
    end
    want = expected_results.pop_front();
    if (beat[31:0] !== want.read_data)
      report_mismatch("read_data", beat[31:0], want.read_data);
    if (beat[38:32] !== want.event_number)
      report_mismatch("event_number", word_t'(beat[38:32]), word_t'(want.event_number));
    if (beat[39] !== want.event_found)
      report_mismatch("event_found", word_t'(beat[39]), word_t'(want.event_found));
    if (beat[43:40] !== want.passed_line)
      report_mismatch("passed_line", word_t'(beat[43:40]), word_t'(want.passed_line));
    if (beat[46:44] !== want.line_requests)
      report_mismatch("line_requests", word_t'(beat[46:44]), word_t'(want.line_requests));
  endtask

  // Check every result at the mid-cycle before the edge that takes it.
  initial begin : result_check
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    end
  end

  // Receiver: a random stall before each result, plus a long hold-off on request.
  initial begin : result_sink
    int unsigned gap;
    bit          took;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_req) @(posedge clk_i);
        hold_off_req = 0;
      end
      gap = recv_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        took = m_axis_tvalid;
        @(posedge clk_i);
      end while (!took);
    end
  end

  // Abort a hung run.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Mask words, holes in the map, absent groups and arrivals on non-status words.
  task automatic test_register_map();
    send_item(make_item(CMD_READ,  IDX_STATUS0,      NO_BITS,  LINE_OTHER_LO));
    send_item(make_item(CMD_WRITE, mask_index(0, 0), ALL_ONES, LINE_OTHER_HI));
    send_item(make_item(CMD_WRITE, mask_index(2, 2), ALL_ONES, LINE_OTHER_LO));
    send_item(make_item(CMD_WRITE, mask_index(1, 1), NO_BITS,  LINE_OTHER_LO));
    send_item(make_item(CMD_WRITE, IDX_TOP,          ALL_ONES, LINE_OTHER_LO));
    send_item(make_item(CMD_WRITE, IDX_HOLE,         ALL_ONES, LINE_OTHER_LO));
    send_item(make_item(CMD_READ,  IDX_HOLE,         NO_BITS,  LINE_OTHER_LO));
    send_item(make_item(CMD_READ,  IDX_TOP,          NO_BITS,  LINE_OTHER_LO));
    send_item(make_item(CMD_READ,  mask_index(0, 0), NO_BITS,  LINE_OTHER_LO));
    send_item(make_item(CMD_READ,  mask_index(2, 2), NO_BITS,  LINE_OTHER_LO));
    send_item(make_item(CMD_EVENT, IDX_HOLE,         ALL_ONES, LINE_OTHER_LO));
    send_item(make_item(CMD_EVENT, mask_index(1, 1), ALL_ONES, LINE_OTHER_LO));
    send_item(make_item(CMD_READ,  IDX_STATUS1,      NO_BITS,  LINE_OTHER_LO));
  endtask

  // Served lines with and without pending events, unserved lines, clear by ones.
  task automatic test_demux_lines();
    send_item(make_item(CMD_EVENT, IDX_STATUS0, TOP_BIT,  LINE_OTHER_LO));
    send_item(make_item(CMD_DEMUX, IDX_STATUS0, NO_BITS,  LINE_LVL0));
    send_item(make_item(CMD_EVENT, IDX_STATUS2, LOW_BIT,  LINE_OTHER_LO));
    send_item(make_item(CMD_DEMUX, IDX_STATUS0, NO_BITS,  LINE_LVL2));
    send_item(make_item(CMD_DEMUX, IDX_STATUS0, NO_BITS,  LINE_LVL1));
    send_item(make_item(CMD_DEMUX, IDX_STATUS0, NO_BITS,  LINE_OTHER_LO));
    send_item(make_item(CMD_DEMUX, IDX_STATUS0, ALL_ONES, LINE_OTHER_HI));
    send_item(make_item(CMD_WRITE, IDX_STATUS0, ALL_ONES, LINE_OTHER_LO));
    send_item(make_item(CMD_DEMUX, IDX_STATUS0, NO_BITS,  LINE_LVL0));
    send_item(make_item(CMD_READ,  IDX_STATUS2, NO_BITS,  LINE_OTHER_LO));
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so the
  // block fills and stalls its input; then pause until all results are in.
  task automatic test_backpressure();
    wait_until_drained();
    send_idle_en = 1'b0;
    hold_off_req = HOLD_OFF_CYCLES;
    for (int i = 0; i < BURST_ITEMS; i++) send_item(random_item());
    wait_until_drained();
  endtask

  // Long random run; switch idling on and off in stretches.
  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % MODE_STRETCH == 0) begin
        send_idle_en = $urandom_range(0, 2) != 0;
        recv_idle_en = $urandom_range(0, 2) != 0;
      end
      send_item(random_item());
    end
  endtask

  initial begin : test_sequence
    // Hold every input at a known value from time zero.
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    send_idle_en  = 1'b1;
    recv_idle_en  = 1'b1;
    hold_off_req  = 0;
    mismatch_cnt  = 0;
    foreach (status_words[g]) status_words[g] = '0;
    foreach (mask_words[l, g]) mask_words[l][g] = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_map();
    test_demux_lines();
    test_backpressure();
    test_random_traffic();

    // Let the pipe empty, then a few more cycles for stray results.
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/eic_pkg.sv
design/eic_regs.sv
design/eic_demux.sv
design/event_interrupt_controller.sv
design/eic_checker.sv
dv/event_interrupt_controller_test.sv
